// ===== rtl/cae_pkg.sv =====
// ----------------------------------------------------------------------------
// cae_pkg
// Shared types and constants for the chain autocorrelation / ESS block.
// ----------------------------------------------------------------------------
`default_nettype none

package cae_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 4096;
  localparam int unsigned MAX_LAG_DEF     = 50;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned LAG_W      = 6;
  localparam int unsigned ACR_W      = 32;
  localparam int unsigned ESS_W      = 29;
  localparam int unsigned CUTOFF_W   = 31;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned VAR_W      = 48;
  localparam int unsigned DEN_W      = 40;
  localparam int unsigned DIV_W      = 64;
  localparam int unsigned DIV_CNT_W  = 7;
  localparam int unsigned FRAC_STEPS = 30;
  localparam int unsigned ESS_SHIFT  = 46;

  localparam logic [DEN_W-1:0]    ONE_Q30     = DEN_W'(64'd1 << 30);
  localparam logic [LAG_W-1:0]    MAX_LAG_RST = LAG_W'(50);
  localparam logic [CUTOFF_W-1:0] CUTOFF_RST  = CUTOFF_W'(53687091);

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAG    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ESS_CUTOFF = CFG_IDX_W'(1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       end_of_chain;
  } cae_in_t;

  typedef struct packed {
    logic [LAG_W-1:0]        lag_index;
    logic signed [ACR_W-1:0] autocorr_value;
    logic [ESS_W-1:0]        ess_value;
    logic                    last_result;
  } cae_out_t;

  typedef struct packed {
    logic load_en;
    logic mean_start;
    logic mean_load;
    logic mean_zero;
    logic var_clr;
    logic var_start;
    logic var_load;
    logic lag_clr;
    logic lag_inc;
    logic acc_clr;
    logic mem_rd;
    logic dev_load;
    logic mul_lo;
    logic mul_hi;
    logic acc_add;
    logic qden_load;
    logic q_start;
    logic q_load;
    logic r_flat;
    logic r_zero;
    logic ess_init;
    logic ess_upd;
    logic ess_start;
    logic ess_load;
    logic ess_zero;
    logic out_load;
    logic chain_clr;
  } cae_cmd_t;

  typedef struct packed {
    logic in_end;
    logic n_zero;
    logic n_lt2;
    logic flat;
    logic lag_ge_n;
    logic term_last;
    logic div_done;
    logic lag_last;
    logic out_free;
  } cae_sts_t;

endpackage

`default_nettype wire

// ===== rtl/cae_div.sv =====
// ----------------------------------------------------------------------------
// cae_div
// Restoring divider, one quotient bit per cycle. Runs the integer bits of the
// dividend and, on request, extra fraction bits with zeros shifted in.
// ----------------------------------------------------------------------------
`default_nettype none

module cae_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic                       frac_i,
  input  wire logic [cae_pkg::DIV_W-1:0]  num_i,
  input  wire logic [cae_pkg::DIV_W-1:0]  den_i,
  output logic                            done_o,
  output logic [cae_pkg::DIV_W-1:0]       quot_o,
  output logic                            ovf_o,
  output logic                            rem_nz_o
);

  localparam int unsigned W = cae_pkg::DIV_W;

  logic [W-1:0] num_q, den_q, rem_q, quot_q;
  logic         ovf_q, busy_q, done_q;
  logic [cae_pkg::DIV_CNT_W-1:0] cnt_q;

  logic [W:0] rem_sh, rem_sub;
  logic       ge;

  assign rem_sh  = {rem_q, num_q[W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= frac_i ? cae_pkg::DIV_CNT_W'(W + cae_pkg::FRAC_STEPS - 1)
                         : cae_pkg::DIV_CNT_W'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
      ovf_q  <= 1'b0;
    end else if (busy_q) begin
      num_q  <= {num_q[W-2:0], 1'b0};
      rem_q  <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
      quot_q <= {quot_q[W-2:0], ge};
      ovf_q  <= ovf_q | quot_q[W-1];
    end
  end

  assign done_o   = done_q;
  assign quot_o   = quot_q;
  assign ovf_o    = ovf_q;
  assign rem_nz_o = |rem_q;

endmodule

`default_nettype wire

// ===== rtl/cae_dp.sv =====
// ----------------------------------------------------------------------------
// cae_dp
// Datapath: sample store, running total, deviation multiplier, saturating
// lag accumulator, shared divider, ESS bookkeeping, output register and the
// configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cae_dp #(
  parameter int unsigned MAX_SAMPLES = cae_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned MAX_LAG     = cae_pkg::MAX_LAG_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire cae_pkg::cae_cmd_t               cmd_i,
  output cae_pkg::cae_sts_t                    sts_o,
  input  wire logic                            in_valid_i,
  input  wire cae_pkg::cae_in_t                in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output cae_pkg::cae_out_t                    out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [cae_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [cae_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned TW  = cae_pkg::SAMPLE_W + AW;
  localparam int unsigned DW  = cae_pkg::SAMPLE_W + 1;
  localparam int unsigned HW  = DW - 16;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned MW  = HW + DW;
  localparam int unsigned LW  = cae_pkg::LAG_W;
  localparam int unsigned XW  = cae_pkg::DIV_W;

  // configuration
  logic [LW-1:0]                max_lag_q;
  logic [cae_pkg::CUTOFF_W-1:0] cutoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lag_q <= cae_pkg::MAX_LAG_RST;
      cutoff_q  <= cae_pkg::CUTOFF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cae_pkg::CFG_MAX_LAG:    max_lag_q <= cfg_data_i[LW-1:0];
        cae_pkg::CFG_ESS_CUTOFF: cutoff_q  <= cfg_data_i[cae_pkg::CUTOFF_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LW-1:0] lag_top;
  assign lag_top = (max_lag_q > LW'(MAX_LAG)) ? LW'(MAX_LAG) : max_lag_q;

  // load
  logic [CW-1:0]        count_q;
  logic signed [TW-1:0] total_q;
  logic                 in_acc, store_en;
  logic signed [cae_pkg::SAMPLE_W-1:0] mem [MAX_SAMPLES];

  assign in_acc   = in_valid_i && cmd_i.load_en;
  assign store_en = in_acc && (count_q < CW'(MAX_SAMPLES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
    end else if (cmd_i.chain_clr) begin
      count_q <= '0;
      total_q <= '0;
    end else if (store_en) begin
      count_q <= count_q + 1'b1;
      total_q <= total_q + TW'(in_data_i.sample_value);
    end
  end

  // term loop indexes
  logic [LW-1:0] lag_q;
  logic [CW-1:0] idx_q;
  logic [CW:0]   idx_far;

  assign idx_far = {1'b0, idx_q} + (CW+1)'(lag_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_q <= '0;
      idx_q <= '0;
    end else begin
      if (cmd_i.lag_clr)      lag_q <= '0;
      else if (cmd_i.lag_inc) lag_q <= lag_q + 1'b1;
      if (cmd_i.acc_clr)      idx_q <= '0;
      else if (cmd_i.acc_add) idx_q <= idx_q + 1'b1;
    end
  end

  logic signed [cae_pkg::SAMPLE_W-1:0] rd0_q, rd1_q;

  always_ff @(posedge clk_i) begin
    if (store_en) mem[count_q[AW-1:0]] <= in_data_i.sample_value;
    if (cmd_i.mem_rd) begin
      rd0_q <= mem[idx_q[AW-1:0]];
      rd1_q <= mem[idx_far[AW-1:0]];
    end
  end

  // deviations and product, low half then high half of the first magnitude
  logic signed [cae_pkg::SAMPLE_W-1:0] mean_q;
  logic signed [DW-1:0] d0, d1;
  logic [DW-1:0]        a_q, b_q;
  logic                 neg_q;
  logic [HW-1:0]        mul_a;
  logic [MW-1:0]        mprod;
  logic [PW-1:0]        prod_q;

  assign d0    = DW'(rd0_q) - DW'(mean_q);
  assign d1    = DW'(rd1_q) - DW'(mean_q);
  assign mul_a = cmd_i.mul_hi ? a_q[DW-1:16] : HW'(a_q[15:0]);
  assign mprod = MW'(mul_a) * MW'(b_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.dev_load) begin
      a_q   <= d0[DW-1] ? DW'(-d0) : DW'(d0);
      b_q   <= d1[DW-1] ? DW'(-d1) : DW'(d1);
      neg_q <= d0[DW-1] ^ d1[DW-1];
    end
    if (cmd_i.mul_lo)      prod_q <= PW'(mprod);
    else if (cmd_i.mul_hi) prod_q <= prod_q + (PW'(mprod) << 16);
  end

  // saturating accumulator
  logic signed [cae_pkg::ACC_W-1:0] acc_q, term, acc_sum, acc_next;
  logic [cae_pkg::ACC_W-1:0]        acc_mag;

  assign term     = neg_q ? -cae_pkg::ACC_W'(prod_q[PW-1:16])
                          :  cae_pkg::ACC_W'(prod_q[PW-1:16]);
  assign acc_sum  = acc_q + term;
  always_comb begin
    acc_next = acc_sum;
    if (acc_q[cae_pkg::ACC_W-1] == term[cae_pkg::ACC_W-1] &&
        acc_sum[cae_pkg::ACC_W-1] != acc_q[cae_pkg::ACC_W-1]) begin
      acc_next = acc_q[cae_pkg::ACC_W-1] ? {1'b1, {(cae_pkg::ACC_W-1){1'b0}}}
                                         : {1'b0, {(cae_pkg::ACC_W-1){1'b1}}};
    end
  end
  assign acc_mag = acc_q[cae_pkg::ACC_W-1] ? (~acc_q + 1'b1) : acc_q;

  // shared divider
  logic [cae_pkg::VAR_W-1:0] var_q;
  logic [XW-1:0]             qden_q;
  logic [cae_pkg::DEN_W-1:0] eden_q;
  logic [TW-1:0]             tot_mag;
  logic [XW-1:0]             div_num, div_den, quot;
  logic                      div_start, div_done, div_ovf, rem_nz;

  assign tot_mag   = total_q[TW-1] ? TW'(-total_q) : TW'(total_q);
  assign div_start = cmd_i.mean_start | cmd_i.var_start | cmd_i.q_start | cmd_i.ess_start;

  always_comb begin
    div_num = XW'(tot_mag);
    div_den = XW'(count_q);
    if (cmd_i.var_start) begin
      div_num = acc_mag;
      div_den = XW'(count_q - 1'b1);
    end else if (cmd_i.q_start) begin
      div_num = acc_mag;
      div_den = qden_q;
    end else if (cmd_i.ess_start) begin
      div_num = XW'(count_q) << cae_pkg::ESS_SHIFT;
      div_den = XW'(eden_q);
    end
  end

  cae_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .frac_i   (cmd_i.q_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .done_o   (div_done),
    .quot_o   (quot),
    .ovf_o    (div_ovf),
    .rem_nz_o (rem_nz)
  );

  // mean rounds toward minus infinity
  logic [cae_pkg::SAMPLE_W:0] mean_up;
  assign mean_up = {1'b0, quot[cae_pkg::SAMPLE_W-1:0]} + (cae_pkg::SAMPLE_W+1)'(rem_nz);

  // (n - lag) * variance
  logic [CW-1:0]                  n_less;
  logic [CW+cae_pkg::VAR_W-1:0]   qprod;
  assign n_less = count_q - CW'(lag_q);
  assign qprod  = (CW+cae_pkg::VAR_W)'(n_less) * (CW+cae_pkg::VAR_W)'(var_q);

  // Q2.30 result with saturation
  logic signed [cae_pkg::ACR_W-1:0] r_q, r_div;
  logic                             q_big;
  assign q_big = div_ovf || (|quot[XW-1:32]);
  always_comb begin
    if (acc_q[cae_pkg::ACC_W-1]) begin
      if (q_big || quot[31:0] > 32'h8000_0000) r_div = 32'sh8000_0000;
      else                                     r_div = -$signed(quot[31:0]);
    end else begin
      if (q_big || quot[31]) r_div = 32'sh7FFF_FFFF;
      else                   r_div = $signed(quot[31:0]);
    end
  end

  logic [cae_pkg::ESS_W-1:0] ess_q;
  logic                      seen_q;
  logic                      below;
  assign below = $signed({r_q[cae_pkg::ACR_W-1], r_q}) < $signed({2'b00, cutoff_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      var_q  <= '0;
      acc_q  <= '0;
      eden_q <= cae_pkg::ONE_Q30;
      seen_q <= 1'b0;
    end else begin
      if (cmd_i.mean_zero)      mean_q <= '0;
      else if (cmd_i.mean_load) mean_q <= total_q[TW-1]
                                          ? cae_pkg::SAMPLE_W'(-mean_up)
                                          : quot[cae_pkg::SAMPLE_W-1:0];
      if (cmd_i.var_clr)        var_q <= '0;
      else if (cmd_i.var_load)  var_q <= quot[cae_pkg::VAR_W-1:0];
      if (cmd_i.acc_clr)        acc_q <= '0;
      else if (cmd_i.acc_add)   acc_q <= acc_next;
      if (cmd_i.ess_init) begin
        eden_q <= cae_pkg::ONE_Q30;
        seen_q <= 1'b0;
      end else if (cmd_i.ess_upd && lag_q != '0 && !seen_q) begin
        if (below) seen_q <= 1'b1;
        else       eden_q <= eden_q + cae_pkg::DEN_W'({r_q, 1'b0});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.qden_load) qden_q <= XW'(qprod);
    if (cmd_i.r_flat)      r_q <= cae_pkg::ACR_W'(cae_pkg::ONE_Q30);
    else if (cmd_i.r_zero) r_q <= '0;
    else if (cmd_i.q_load) r_q <= r_div;
    if (cmd_i.ess_zero)    ess_q <= '0;
    else if (cmd_i.ess_load) begin
      ess_q <= (|quot[XW-1:cae_pkg::ESS_W]) ? {cae_pkg::ESS_W{1'b1}}
                                            : quot[cae_pkg::ESS_W-1:0];
    end
  end

  // output register
  logic               out_valid_q;
  cae_pkg::cae_out_t  out_q;
  logic               lag_last;

  assign lag_last = (lag_q == lag_top);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)            out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (!out_stall_i)  out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.lag_index      <= lag_q;
      out_q.autocorr_value <= r_q;
      out_q.ess_value      <= lag_last ? ess_q : '0;
      out_q.last_result    <= lag_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o.in_end    = in_acc && in_data_i.end_of_chain;
    sts_o.n_zero    = (count_q == '0);
    sts_o.n_lt2     = (count_q < CW'(2));
    sts_o.flat      = (var_q == '0);
    sts_o.lag_ge_n  = ((CW+1)'(lag_q) >= (CW+1)'(count_q));
    sts_o.term_last = (idx_far + 1'b1) >= (CW+1)'(count_q);
    sts_o.div_done  = div_done;
    sts_o.lag_last  = lag_last;
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

endmodule

`default_nettype wire

// ===== rtl/cae_ctrl.sv =====
// ----------------------------------------------------------------------------
// cae_ctrl
// Sequencer: load, mean, variance pass, one pass per lag, ESS and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module cae_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cae_pkg::cae_sts_t sts_i,
  output cae_pkg::cae_cmd_t      cmd_o
);

  localparam logic [4:0] S_LOAD     = 5'd0;
  localparam logic [4:0] S_MEAN     = 5'd1;
  localparam logic [4:0] S_MEAN_W   = 5'd2;
  localparam logic [4:0] S_VAR_INIT = 5'd3;
  localparam logic [4:0] S_T_RD     = 5'd4;
  localparam logic [4:0] S_T_DEV    = 5'd5;
  localparam logic [4:0] S_T_M0     = 5'd6;
  localparam logic [4:0] S_T_M1     = 5'd7;
  localparam logic [4:0] S_T_ACC    = 5'd8;
  localparam logic [4:0] S_VAR_DIV  = 5'd9;
  localparam logic [4:0] S_VAR_W    = 5'd10;
  localparam logic [4:0] S_LAG_INIT = 5'd11;
  localparam logic [4:0] S_LAG      = 5'd12;
  localparam logic [4:0] S_Q_MUL    = 5'd13;
  localparam logic [4:0] S_Q_DIV    = 5'd14;
  localparam logic [4:0] S_Q_W      = 5'd15;
  localparam logic [4:0] S_ESS_UPD  = 5'd16;
  localparam logic [4:0] S_ESS_DIV  = 5'd17;
  localparam logic [4:0] S_ESS_W    = 5'd18;
  localparam logic [4:0] S_EMIT     = 5'd19;

  logic [4:0] state_q, state_d;
  logic       var_pass_q, var_pass_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      var_pass_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      var_pass_q <= var_pass_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    var_pass_d = var_pass_q;
    unique case (state_q)
      S_LOAD: begin
        cmd_o.load_en = 1'b1;
        if (sts_i.in_end) state_d = S_MEAN;
      end
      S_MEAN: begin
        if (sts_i.n_zero) begin
          cmd_o.mean_zero = 1'b1;
          state_d = S_VAR_INIT;
        end else begin
          cmd_o.mean_start = 1'b1;
          state_d = S_MEAN_W;
        end
      end
      S_MEAN_W: begin
        if (sts_i.div_done) begin
          cmd_o.mean_load = 1'b1;
          state_d = S_VAR_INIT;
        end
      end
      S_VAR_INIT: begin
        cmd_o.lag_clr = 1'b1;
        cmd_o.acc_clr = 1'b1;
        if (sts_i.n_lt2) begin
          cmd_o.var_clr = 1'b1;
          state_d = S_LAG_INIT;
        end else begin
          var_pass_d = 1'b1;
          state_d = S_T_RD;
        end
      end
      S_T_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = S_T_DEV;
      end
      S_T_DEV: begin
        cmd_o.dev_load = 1'b1;
        state_d = S_T_M0;
      end
      S_T_M0: begin
        cmd_o.mul_lo = 1'b1;
        state_d = S_T_M1;
      end
      S_T_M1: begin
        cmd_o.mul_hi = 1'b1;
        state_d = S_T_ACC;
      end
      S_T_ACC: begin
        cmd_o.acc_add = 1'b1;
        if (!sts_i.term_last)  state_d = S_T_RD;
        else if (var_pass_q)   state_d = S_VAR_DIV;
        else                   state_d = S_Q_MUL;
      end
      S_VAR_DIV: begin
        cmd_o.var_start = 1'b1;
        state_d = S_VAR_W;
      end
      S_VAR_W: begin
        if (sts_i.div_done) begin
          cmd_o.var_load = 1'b1;
          state_d = S_LAG_INIT;
        end
      end
      S_LAG_INIT: begin
        cmd_o.lag_clr  = 1'b1;
        cmd_o.ess_init = 1'b1;
        var_pass_d = 1'b0;
        state_d = S_LAG;
      end
      S_LAG: begin
        if (sts_i.flat) begin
          cmd_o.r_flat = 1'b1;
          state_d = S_ESS_UPD;
        end else if (sts_i.lag_ge_n) begin
          cmd_o.r_zero = 1'b1;
          state_d = S_ESS_UPD;
        end else begin
          cmd_o.acc_clr = 1'b1;
          state_d = S_T_RD;
        end
      end
      S_Q_MUL: begin
        cmd_o.qden_load = 1'b1;
        state_d = S_Q_DIV;
      end
      S_Q_DIV: begin
        cmd_o.q_start = 1'b1;
        state_d = S_Q_W;
      end
      S_Q_W: begin
        if (sts_i.div_done) begin
          cmd_o.q_load = 1'b1;
          state_d = S_ESS_UPD;
        end
      end
      S_ESS_UPD: begin
        cmd_o.ess_upd = 1'b1;
        state_d = sts_i.lag_last ? S_ESS_DIV : S_EMIT;
      end
      S_ESS_DIV: begin
        if (sts_i.n_zero) begin
          cmd_o.ess_zero = 1'b1;
          state_d = S_EMIT;
        end else begin
          cmd_o.ess_start = 1'b1;
          state_d = S_ESS_W;
        end
      end
      S_ESS_W: begin
        if (sts_i.div_done) begin
          cmd_o.ess_load = 1'b1;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.lag_last) begin
            cmd_o.chain_clr = 1'b1;
            state_d = S_LOAD;
          end else begin
            cmd_o.lag_inc = 1'b1;
            state_d = S_LAG;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/chain_autocorrelation_ess.sv =====
// ----------------------------------------------------------------------------
// chain_autocorrelation_ess
// Sample autocorrelation per lag and effective sample size of one chain.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle into an on-chip store until a word with
// end_of_chain set; samples past MAX_SAMPLES are dropped. The input then
// stalls while the block computes: mean (one divide), a variance pass and
// one pass per lag, each term stepping through read, deviation, the two
// multiply halves and accumulate on a single read port pair and a 17x33
// multiplier, plus a divide per lag and a final ESS divide. For n samples
// and top lag L, L+1 result words come out in lag order, the last one
// carrying the ESS. Output stalls only delay emission.
`default_nettype none

module chain_autocorrelation_ess #(
  parameter int unsigned MAX_SAMPLES = cae_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned MAX_LAG     = cae_pkg::MAX_LAG_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire cae_pkg::cae_in_t                in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output cae_pkg::cae_out_t                    out_data_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [cae_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [cae_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  cae_pkg::cae_cmd_t cmd;
  cae_pkg::cae_sts_t sts;

  assign in_stall_o  = ~cmd.load_en;
  assign cfg_ready_o = 1'b1;

  cae_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  cae_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_LAG     (MAX_LAG)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

`default_nettype wire

// ===== rtl/cae_checker.sv =====
// ----------------------------------------------------------------------------
// cae_sva
// Port-level checks for chain_autocorrelation_ess, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cae_sva #(
  parameter int unsigned MAX_LAG = cae_pkg::MAX_LAG_DEF
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_stall_o,
  input wire cae_pkg::cae_in_t                in_data_i,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire cae_pkg::cae_out_t               out_data_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed under stall");

  // end of chain stops intake while computing
  a_end_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.end_of_chain |=> in_stall_o)
    else $error("input not stalled after end of chain");

  a_ess_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_result |-> out_data_o.ess_value == '0)
    else $error("ess on a non-last word");

  a_lag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.lag_index <= cae_pkg::LAG_W'(MAX_LAG))
    else $error("lag index out of range");

endmodule

bind chain_autocorrelation_ess cae_sva #(.MAX_LAG(MAX_LAG)) u_cae_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== tb/cae_checker.sv =====
// ----------------------------------------------------------------------------
// cae_checker
// Scoreboard for the chain autocorrelation / ESS block.
// ----------------------------------------------------------------------------
// Watches the input, output and register channels. Keeps its own sample
// store, running sum and register copies. On the word that ends a chain it
// works out every lag's autocorrelation and the ESS, then queues them.
// Every output word is checked field by field against the oldest queued one.
// ----------------------------------------------------------------------------
`default_nettype none

module cae_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic                           in_stall_i,
  input  wire cae_pkg::cae_in_t               in_data_i,
  input  wire logic                           out_valid_i,
  input  wire logic                           out_stall_i,
  input  wire cae_pkg::cae_out_t              out_data_i,
  input  wire logic                           cfg_valid_i,
  input  wire logic                           cfg_ready_i,
  input  wire logic [cae_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [cae_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);

  localparam longint I64_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam longint I64_MIN = 64'h8000_0000_0000_0000;

  int                 chain_buf [cae_pkg::MAX_SAMPLES_DEF];
  int unsigned        chain_len;
  longint             chain_sum;
  longint             mean_q16;
  logic [5:0]         top_lag_reg;
  logic [30:0]        cutoff_reg;
  cae_pkg::cae_out_t  lag_results [$];

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-(v + 1)) + 64'd1 : 64'(v);
  endfunction

  function automatic longint sat_sum(longint a, longint t);
    if (t >= 0 && a > I64_MAX - t) return I64_MAX;
    if (t < 0 && a < I64_MIN - t) return I64_MIN;
    return a + t;
  endfunction

  function automatic longint cov_sum(int unsigned n, int unsigned lag);
    longint      acc;
    longint      d1;
    longint      d2;
    logic [63:0] m;
    acc = 0;
    for (int unsigned i = 0; i + lag < n; i++) begin
      d1 = longint'(chain_buf[i]) - mean_q16;
      d2 = longint'(chain_buf[i+lag]) - mean_q16;
      m = (magnitude(d1) * magnitude(d2)) >> 16;
      acc = sat_sum(acc, ((d1 < 0) != (d2 < 0)) ? -longint'(m) : longint'(m));
    end
    return acc;
  endfunction

  // acc * 2^30 / den, toward zero, saturated to 32-bit signed
  function automatic longint scale_q30(longint acc, logic [63:0] den);
    logic [63:0] mag;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] q;
    mag = magnitude(acc);
    quo = mag / den;
    rem = mag % den;
    if (quo >= 4) begin
      q = 64'd1 << 33;
    end else begin
      q = quo;
      for (int k = 0; k < 30; k++) begin
        q = q << 1;
        if (rem >= den - rem) begin
          rem = rem - (den - rem);
          q = q | 64'd1;
        end else begin
          rem = rem << 1;
        end
      end
    end
    if (acc < 0) begin
      if (q > (64'd1 << 31)) return -(longint'(1) << 31);
      return -longint'(q);
    end
    if (q > (64'd1 << 31) - 1) return (longint'(1) << 31) - 1;
    return longint'(q);
  endfunction

  task automatic predict_chain();
    int unsigned       n;
    int unsigned       top;
    logic [63:0]       var_q16;
    logic [63:0]       ess_den;
    logic [63:0]       ess;
    bit                flat;
    bit                stopped;
    longint            r;
    cae_pkg::cae_out_t w;
    n = chain_len;
    top = (top_lag_reg < cae_pkg::MAX_LAG_DEF) ? top_lag_reg : cae_pkg::MAX_LAG_DEF;
    if (n == 0) mean_q16 = 0;
    else if (chain_sum >= 0) mean_q16 = chain_sum / longint'(n);
    else mean_q16 = -((-chain_sum + longint'(n) - 1) / longint'(n));
    var_q16 = 0;
    if (n >= 2) var_q16 = magnitude(cov_sum(n, 0)) / 64'(n - 1);
    flat = (n < 2) || (var_q16 == 0);
    ess_den = 64'd1 << 30;
    stopped = 0;
    for (int unsigned lag = 0; lag <= top; lag++) begin
      if (flat) r = longint'(1) << 30;
      else if (lag >= n) r = 0;
      else r = scale_q30(cov_sum(n, lag), 64'(n - lag) * var_q16);
      if (lag >= 1 && !stopped) begin
        if (r < longint'(cutoff_reg)) stopped = 1;
        else ess_den = ess_den + 2 * 64'(r);
      end
      w.lag_index      = 6'(lag);
      w.autocorr_value = 32'(r);
      w.ess_value      = '0;
      w.last_result    = (lag == top);
      lag_results = {lag_results, w};
    end
    ess = (64'(n) << 46) / ess_den;
    if (ess > (64'd1 << 29) - 1) ess = (64'd1 << 29) - 1;
    lag_results[lag_results.size()-1].ess_value = 29'(ess);
    chain_len = 0;
    chain_sum = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cae_pkg::cae_out_t exp_w;
    if (!rst_ni) begin
      chain_len = 0;
      chain_sum = 0;
      mean_q16 = 0;
      top_lag_reg = cae_pkg::MAX_LAG_RST;
      cutoff_reg = cae_pkg::CUTOFF_RST;
      lag_results.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == cae_pkg::CFG_MAX_LAG) top_lag_reg = cfg_data_i[5:0];
        else if (cfg_index_i == cae_pkg::CFG_ESS_CUTOFF) cutoff_reg = cfg_data_i[30:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (lag_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected output word %p", out_data_i);
        end else begin
          exp_w = lag_results.pop_front();
          if (out_data_i.lag_index !== exp_w.lag_index ||
              out_data_i.autocorr_value !== exp_w.autocorr_value ||
              out_data_i.ess_value !== exp_w.ess_value ||
              out_data_i.last_result !== exp_w.last_result) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: expected %p, got %p", exp_w, out_data_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (chain_len < cae_pkg::MAX_SAMPLES_DEF) begin
          chain_buf[chain_len] = in_data_i.sample_value;
          chain_len++;
          chain_sum += longint'(in_data_i.sample_value);
        end
        if (in_data_i.end_of_chain) predict_chain();
      end
      pending_o = lag_results.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the chain autocorrelation / ESS block.
// ----------------------------------------------------------------------------
// Directed chains first (single sample, flat, extreme values, lags past the
// chain, clamped lag register), then random chains of random, correlated,
// flat and alternating samples across four idle/stall mixes, with the
// registers rewritten between some chains.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int WATCHDOG_LIMIT = 20000;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  cae_pkg::cae_in_t               in_data_i;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  cae_pkg::cae_out_t              out_data_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [cae_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [cae_pkg::CFG_DATA_W-1:0] cfg_data_i;
  int                             fail_count;
  int                             pending;
  int                             send_idle_pct;
  int                             recv_stall_pct;
  int                             words_sent;
  int                             quiet_cycles = 0;

  chain_autocorrelation_ess DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  cae_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [31:0] sample, input logic eoc);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= {sample, eoc};
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    words_sent++;
  endtask

  // hold off until all results are back, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (200) @(posedge clk_i);
  endtask

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(input logic [cae_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic set_regs(input logic [5:0] top_lag, input logic [30:0] cutoff);
    drain();
    write_reg(cae_pkg::CFG_MAX_LAG, {26'($urandom_range(0, 32'h03ff_ffff)), top_lag});
    write_reg(cae_pkg::CFG_ESS_CUTOFF, {1'($urandom_range(1)), cutoff});
    cfg_valid_i <= 1'b0;
  endtask

  // kinds: 0 full random, 1 correlated walk, 2 constant, 3 alternating
  task automatic send_chain(input int len, input int kind);
    logic [31:0] x;
    int          step;
    x = $urandom;
    step = 1 << $urandom_range(4, 20);
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: x = $urandom;
        1: x = x + $urandom_range(0, 2 * step) - step;
        2: ;
        default: x = ~x + (i % 3);
      endcase
      send_word(x, i == len - 1);
    end
  endtask

  initial begin
    int len;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    words_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset registers, single sample chain
    send_word(32'h0001_0000, 1'b1);
    // lag register above the limit, top cutoff
    set_regs(6'd63, 31'h4000_0000);
    send_chain(3, 2);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7fff_ffff, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h7fff_ffff, 1'b1);
    set_regs(6'd5, 31'd0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h0003_0000, 1'b1);
    set_regs(6'd0, 31'h7fff_ffff);
    send_chain(6, 1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      words_sent = 0;
      while (words_sent < 75) begin
        if ($urandom_range(3) == 0)
          set_regs(($urandom_range(9) == 0) ? 6'($urandom_range(50, 63))
                                            : 6'($urandom_range(0, 12)),
                   ($urandom_range(4) == 0) ? 31'($urandom_range(0, 1))
                                            : 31'($urandom_range(0, 32'h4000_0000)));
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        send_chain(len, $urandom_range(3));
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
